/* hw/rtl/smkt_pkg.sv */
// Shared types and codes for the sticky modifier key tracker.
// No dependencies; every other file of the block imports this package.
package smkt_pkg;

    // Operation carried by each input beat.
    typedef enum logic [1:0] {
        CMD_KEY_DOWN = 2'd0,
        CMD_KEY_UP   = 2'd1,
        CMD_KEYPRESS = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    // Which key the event refers to.
    typedef enum logic [1:0] {
        KEY_SHIFT = 2'd0,
        KEY_ALT   = 2'd1,
        KEY_SYM   = 2'd2,
        KEY_NONE  = 2'd3
    } t_key;

    localparam int unsigned NUM_MODS   = 3;
    localparam int unsigned FLAG_W     = 5;
    localparam int unsigned LEVEL_W    = 2;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

    typedef logic [FLAG_W-1:0]  t_flags;
    typedef logic [LEVEL_W-1:0] t_level;

    // Flag masks within one modifier's flag word.
    localparam t_flags F_ON       = 5'b00001;
    localparam t_flags F_LOCKED   = 5'b00010;
    localparam t_flags F_USED     = 5'b00100;
    localparam t_flags F_PRESSED  = 5'b01000;
    localparam t_flags F_RELEASED = 5'b10000;

    localparam t_level LVL_OFF    = 2'd0;
    localparam t_level LVL_ACTIVE = 2'd1;
    localparam t_level LVL_LOCKED = 2'd2;

    // Per-modifier control handed to a flag unit.
    typedef struct packed {
        t_cmd cmd;
        logic sel;      // key event names this modifier, or its clear mask bit
        logic chorded;
    } t_flag_ctl;

endpackage

/* hw/rtl/smkt_flag_unit.sv */
// Next-state logic for one modifier's five flags and its reported level.
// Depends on smkt_pkg.
module smkt_flag_unit
    import smkt_pkg::*;
(
    input  t_flag_ctl i_ctl,
    input  t_flags    i_flags,
    output t_flags    o_flags,
    output t_level    o_level
);

    t_flags f;

    assign f = i_flags;

    always_comb begin
        o_flags = f;
        unique case (i_ctl.cmd)
            CMD_KEY_DOWN: begin
                if (i_ctl.sel) begin
                    // Priority chain: the first flag that is set decides.
                    if ((f & F_PRESSED) != '0) begin
                        o_flags = f;
                    end else if ((f & F_RELEASED) != '0) begin
                        o_flags = F_ON | F_LOCKED;
                    end else if ((f & F_USED) != '0) begin
                        o_flags = f;
                    end else if ((f & F_LOCKED) != '0) begin
                        o_flags = '0;
                    end else begin
                        o_flags = f | F_ON | F_PRESSED;
                    end
                end
            end
            CMD_KEY_UP: begin
                if (i_ctl.sel) begin
                    if (!i_ctl.chorded || (f & F_USED) != '0) begin
                        o_flags = '0;
                    end else if ((f & F_PRESSED) != '0) begin
                        o_flags = f | F_ON | F_RELEASED;
                    end
                end
            end
            CMD_KEYPRESS: begin
                if ((f & F_PRESSED) != '0) begin
                    o_flags = F_ON | F_USED;
                end else if ((f & F_RELEASED) != '0) begin
                    o_flags = '0;
                end
            end
            CMD_CLEAR: begin
                if (i_ctl.sel && (f & F_LOCKED) != '0) begin
                    o_flags = '0;
                end
            end
            default: o_flags = f;
        endcase
    end

    always_comb begin
        if ((o_flags & F_LOCKED) != '0) begin
            o_level = LVL_LOCKED;
        end else if ((o_flags & F_ON) != '0) begin
            o_level = LVL_ACTIVE;
        end else begin
            o_level = LVL_OFF;
        end
    end

endmodule

/* hw/rtl/sticky_modifier_key_tracker.sv */
// Top level of the sticky modifier key tracker: input register, flag units, result register.
// Depends on smkt_pkg and smkt_flag_unit.
//
// Tracks sticky shift, alt and sym modifiers. Each input beat carries one event (key down,
// key up, ordinary keypress, clear locked) and produces exactly one result beat holding the
// three modifier levels, a handled bit and the fifteen raw flags after the update. The block
// takes one beat per cycle while the output is not stalled: the flag update is a single short
// pass from the input register to the result register, and a stalled output only holds both
// registers in place. Each beat is held first in the input register and its result then in the
// result register, where it stays until it is taken.
module sticky_modifier_key_tracker
    import smkt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [1:0] modifier_key, [2] chorded_toggled, [5:3] clear_mask, [7:6] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] cmd
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [1:0] shift_level, [3:2] alt_level, [5:4] sym_level, [6] handled,
    // [21:7] flags_word, [23:22] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic  r_in_valid;
    t_cmd  r_in_cmd;
    t_key  r_in_key;
    logic  r_in_chorded;
    logic [NUM_MODS-1:0] r_in_mask;

    t_flags r_flags [NUM_MODS];
    t_flags n_flags [NUM_MODS];
    t_level n_level [NUM_MODS];

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic advance;
    logic s_fire;
    logic handled;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_cmd     <= t_cmd'(i_s_tuser[1:0]);
            r_in_key     <= t_key'(i_s_tdata[1:0]);
            r_in_chorded <= i_s_tdata[2];
            r_in_mask    <= i_s_tdata[5:3];
        end
    end

    genvar m;
    generate
        for (m = 0; m < NUM_MODS; m++) begin : g_mod
            t_flag_ctl ctl;

            always_comb begin
                ctl.cmd     = r_in_cmd;
                ctl.chorded = r_in_chorded;
                if (r_in_cmd == CMD_CLEAR) begin
                    ctl.sel = r_in_mask[m];
                end else begin
                    ctl.sel = (r_in_key == t_key'(2'(m)));
                end
            end

            smkt_flag_unit u_flag (
                .i_ctl   (ctl),
                .i_flags (r_flags[m]),
                .o_flags (n_flags[m]),
                .o_level (n_level[m])
            );

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_flags[m] <= '0;
                end else if (r_in_valid && advance) begin
                    r_flags[m] <= n_flags[m];
                end
            end
        end
    endgenerate

    assign handled = (r_in_cmd == CMD_KEY_DOWN || r_in_cmd == CMD_KEY_UP)
                     && (r_in_key != KEY_NONE);

    assign n_out_data = {2'b00, n_flags[2], n_flags[1], n_flags[0], handled,
                         n_level[2], n_level[1], n_level[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* hw/rtl/smkt_checker.sv */
// Port-level assertions for the sticky modifier key tracker, bound to the top level.
// Depends on smkt_pkg and sticky_modifier_key_tracker.
module smkt_checker
    import smkt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    // A result waiting to be taken keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // Nothing is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // The shift and sym level fields agree with the on and locked flags of their modifiers.
    a_shift_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] ==
            (o_m_tdata[8] ? LVL_LOCKED : (o_m_tdata[7] ? LVL_ACTIVE : LVL_OFF)))
        else $error("shift level disagrees with flags");

    a_sym_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[5:4] ==
            (o_m_tdata[18] ? LVL_LOCKED : (o_m_tdata[17] ? LVL_ACTIVE : LVL_OFF)))
        else $error("sym level disagrees with flags");

    // Input is never refused while the output side is free.
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output");

endmodule

bind sticky_modifier_key_tracker smkt_checker u_smkt_checker (.*);
